// ===== sv/gbn_pkg.sv =====
// ----------------------------------------------------------------------------
// Go-back-N link controller package
// Shared constants, codes and structure types for the link controller.
// ----------------------------------------------------------------------------
package gbn_pkg;

    localparam int SEQ_MAX_DEF    = 7;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int PAYLOAD_W      = 32;
    localparam int SEQ_FIELD_W    = 3;

    typedef enum logic [1:0] {
        MODE_SEND    = 2'd0,
        MODE_FRAME   = 2'd1,
        MODE_TIMEOUT = 2'd2,
        MODE_UNUSED  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_FRAME   = 2'd0,
        KIND_DELIVER = 2'd1,
        KIND_STATUS  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_RESULT = 2'd1,
        ST_RETX   = 2'd2
    } state_t;

    typedef struct packed {
        mode_t                  mode;
        logic [PAYLOAD_W-1:0]   payload;
        logic [SEQ_FIELD_W-1:0] rx_seq;
        logic [SEQ_FIELD_W-1:0] rx_ack;
    } in_t;

    typedef struct packed {
        kind_t                  result_kind;
        logic [PAYLOAD_W-1:0]   out_data;
        logic [SEQ_FIELD_W-1:0] out_seq;
        logic [SEQ_FIELD_W-1:0] out_ack;
        logic                   window_open;
        logic                   last;
    } out_t;

    typedef struct packed {
        logic do_send;
        logic do_frame;
        logic do_status;
        logic retx_start;
        logic retx_pop;
        logic retx_read;
        logic show_retx;
    } cmd_t;

    typedef struct packed {
        logic window_full;
        logic parity_err;
        logic count_zero;
        logic retx_last;
    } sts_t;

endpackage

// ===== sv/gbn_stream_if.sv =====
// ----------------------------------------------------------------------------
// Go-back-N stream interface
// Valid/ready channel that carries one payload structure per transaction.
// ----------------------------------------------------------------------------
interface gbn_stream_if #(
    parameter type payload_t = logic
);

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

// ===== sv/gbn_ram.sv =====
// ----------------------------------------------------------------------------
// Go-back-N generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module gbn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/gbn_ctrl.sv =====
// ----------------------------------------------------------------------------
// Go-back-N controller
// Sequences one transaction at a time and steps the retransmit burst.
// ----------------------------------------------------------------------------
module gbn_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  gbn_pkg::mode_t in_mode,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  gbn_pkg::sts_t sts,
    output gbn_pkg::cmd_t cmd
);

    gbn_pkg::state_t state_reg;
    gbn_pkg::state_t state_next;
    logic            take;
    logic            start_retx;

    assign take       = in_valid && (state_reg == gbn_pkg::ST_IDLE);
    assign start_retx = (in_mode == gbn_pkg::MODE_TIMEOUT) && !sts.count_zero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = start_retx ? gbn_pkg::ST_RETX : gbn_pkg::ST_RESULT;
                end
            end
            gbn_pkg::ST_RESULT:
            begin
                if (out_ready)
                begin
                    state_next = gbn_pkg::ST_IDLE;
                end
            end
            gbn_pkg::ST_RETX:
            begin
                if (out_ready && sts.retx_last)
                begin
                    state_next = gbn_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gbn_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        out_valid      = 1'b0;
        cmd            = '0;
        case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                in_ready       = 1'b1;
                cmd.do_send    = take && (in_mode == gbn_pkg::MODE_SEND) && !sts.window_full;
                cmd.do_frame   = take && (in_mode == gbn_pkg::MODE_FRAME) && !sts.parity_err;
                cmd.retx_start = take && start_retx;
                cmd.retx_read  = take && start_retx;
                cmd.do_status  = take && !cmd.do_send && !cmd.do_frame && !start_retx;
            end
            gbn_pkg::ST_RESULT:
            begin
                out_valid = 1'b1;
            end
            gbn_pkg::ST_RETX:
            begin
                out_valid     = 1'b1;
                cmd.show_retx = 1'b1;
                cmd.retx_pop  = out_ready;
                cmd.retx_read = out_ready && !sts.retx_last;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/gbn_datapath.sv =====
// ----------------------------------------------------------------------------
// Go-back-N datapath
// Window counters, packet store, acknowledgment release and result register.
// ----------------------------------------------------------------------------
module gbn_datapath #(
    parameter int SEQ_MAX    = gbn_pkg::SEQ_MAX_DEF,
    parameter int DATA_WIDTH = gbn_pkg::DATA_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  gbn_pkg::in_t  req_data,
    input  gbn_pkg::cmd_t cmd,
    output gbn_pkg::sts_t sts,
    output gbn_pkg::out_t rsp_data
);

    localparam int SEQ_MOD = SEQ_MAX + 1;
    localparam int SEQ_W   = $clog2(SEQ_MOD);
    localparam int D_W     = SEQ_W + 1;
    localparam int CMP_W   = ((SEQ_W > gbn_pkg::SEQ_FIELD_W) ? SEQ_W : gbn_pkg::SEQ_FIELD_W) + 1;
    localparam int STORE_W = (DATA_WIDTH < gbn_pkg::PAYLOAD_W) ? DATA_WIDTH : gbn_pkg::PAYLOAD_W;

    logic [SEQ_W-1:0]   next_send_reg, next_send_next;
    logic [SEQ_W-1:0]   oldest_reg, oldest_next;
    logic [SEQ_W-1:0]   expected_reg, expected_next;
    logic [SEQ_W-1:0]   count_reg, count_next;
    logic [SEQ_W-1:0]   left_reg, left_next;
    gbn_pkg::kind_t     kind_reg, kind_next;
    logic [STORE_W-1:0] data_reg, data_next;
    logic [SEQ_W-1:0]   seq_reg, seq_next;

    logic [STORE_W-1:0] payload_m;
    logic [STORE_W-1:0] rd_data;
    logic [SEQ_W-1:0]   rd_addr;
    logic [CMP_W-1:0]   rack_w;
    logic [SEQ_W-1:0]   rack_s;
    logic               rack_ok;
    logic               deliver;
    logic [D_W-1:0]     dist_raw;
    logic [D_W-1:0]     dist_mod;
    logic [SEQ_W-1:0]   dist_s;
    logic               release_hit;
    logic [SEQ_W-1:0]   seq_sel;
    logic [CMP_W-1:0]   seq_wide;
    logic [SEQ_W-1:0]   ack_s;
    logic [CMP_W-1:0]   ack_wide;

    function automatic logic [SEQ_W-1:0] seq_inc(input logic [SEQ_W-1:0] s);
        return (s == SEQ_W'(SEQ_MAX)) ? '0 : s + SEQ_W'(1);
    endfunction

    assign payload_m = req_data.payload[STORE_W-1:0];
    assign rack_w    = CMP_W'(req_data.rx_ack);
    assign rack_s    = rack_w[SEQ_W-1:0];
    assign rack_ok   = rack_w < CMP_W'(SEQ_MOD);
    assign deliver   = CMP_W'(req_data.rx_seq) == CMP_W'(expected_reg);
    assign dist_raw  = {1'b0, rack_s} + D_W'(SEQ_MOD) - {1'b0, oldest_reg};
    assign dist_mod  = (dist_raw >= D_W'(SEQ_MOD)) ? dist_raw - D_W'(SEQ_MOD) : dist_raw;
    assign dist_s    = dist_mod[SEQ_W-1:0];
    assign release_hit = rack_ok && (dist_s < count_reg);

    assign sts.window_full = count_reg == SEQ_W'(SEQ_MAX);
    assign sts.parity_err  = ^payload_m;
    assign sts.count_zero  = count_reg == '0;
    assign sts.retx_last   = left_reg == SEQ_W'(1);

    assign rd_addr = cmd.retx_start ? oldest_reg : seq_inc(next_send_reg);

    gbn_ram #(
        .WIDTH (STORE_W),
        .DEPTH (SEQ_MOD)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.do_send),
        .wr_addr (next_send_reg),
        .wr_data (payload_m),
        .rd_en   (cmd.retx_read),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        next_send_next = next_send_reg;
        oldest_next    = oldest_reg;
        expected_next  = expected_reg;
        count_next     = count_reg;
        left_next      = left_reg;
        if (cmd.do_send)
        begin
            next_send_next = seq_inc(next_send_reg);
            count_next     = count_reg + SEQ_W'(1);
        end
        if (cmd.do_frame)
        begin
            if (deliver)
            begin
                expected_next = seq_inc(expected_reg);
            end
            if (release_hit)
            begin
                count_next  = count_reg - dist_s - SEQ_W'(1);
                oldest_next = seq_inc(rack_s);
            end
        end
        if (cmd.retx_start)
        begin
            next_send_next = oldest_reg;
            left_next      = count_reg;
        end
        if (cmd.retx_pop)
        begin
            next_send_next = seq_inc(next_send_reg);
            left_next      = left_reg - SEQ_W'(1);
        end
    end

    always_comb
    begin
        kind_next = gbn_pkg::KIND_STATUS;
        data_next = '0;
        seq_next  = '0;
        if (cmd.do_send)
        begin
            kind_next = gbn_pkg::KIND_FRAME;
            data_next = payload_m;
            seq_next  = next_send_reg;
        end
        else if (cmd.do_frame && deliver)
        begin
            kind_next = gbn_pkg::KIND_DELIVER;
            data_next = payload_m;
            seq_next  = expected_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_send_reg <= '0;
            oldest_reg    <= '0;
            expected_reg  <= '0;
            count_reg     <= '0;
            left_reg      <= '0;
        end
        else
        begin
            next_send_reg <= next_send_next;
            oldest_reg    <= oldest_next;
            expected_reg  <= expected_next;
            count_reg     <= count_next;
            left_reg      <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.do_send || cmd.do_frame || cmd.do_status)
        begin
            kind_reg <= kind_next;
            data_reg <= data_next;
            seq_reg  <= seq_next;
        end
    end

    assign seq_sel  = cmd.show_retx ? next_send_reg : seq_reg;
    assign seq_wide = CMP_W'(seq_sel);
    assign ack_s    = (expected_reg == '0) ? SEQ_W'(SEQ_MAX) : expected_reg - SEQ_W'(1);
    assign ack_wide = CMP_W'(ack_s);

    assign rsp_data.result_kind = cmd.show_retx ? gbn_pkg::KIND_FRAME : kind_reg;
    assign rsp_data.out_data    = gbn_pkg::PAYLOAD_W'(cmd.show_retx ? rd_data : data_reg);
    assign rsp_data.out_seq     = seq_wide[gbn_pkg::SEQ_FIELD_W-1:0];
    assign rsp_data.out_ack     = ack_wide[gbn_pkg::SEQ_FIELD_W-1:0];
    assign rsp_data.window_open = !sts.window_full;
    assign rsp_data.last        = cmd.show_retx ? sts.retx_last : 1'b1;

    // The outstanding count never exceeds the window size.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= SEQ_W'(SEQ_MAX))
    else $error("outstanding count above window size");

    // A retransmit burst always has at least one frame left to send.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.show_retx |-> (left_reg != '0))
    else $error("retransmit burst with no frames left");

    // A stored send grows the window by exactly one frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.do_send |=> (count_reg == $past(count_reg) + SEQ_W'(1)))
    else $error("send did not advance outstanding count");

    // A retransmit burst restarts from the oldest unacknowledged frame.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.retx_start |=> (next_send_reg == $past(oldest_reg)))
    else $error("retransmit did not rewind the send edge");

endmodule

// ===== sv/go_back_n_link_controller_core.sv =====
// ----------------------------------------------------------------------------
// Go-back-N link controller core
// Sliding-window endpoint: sends, receives, releases acked frames, retransmits.
// ----------------------------------------------------------------------------
// A send, arriving frame or status transaction gives its result in the cycle
// after acceptance; a timeout with frames outstanding gives them one frame per
// cycle from then on while the response side is ready. The controller takes a
// new transaction only in its idle state, so it accepts none before the last
// result is taken. Reset clears the state machine, the sequence counters and
// the outstanding count; the packet store is not cleared and is read only for
// frames already written.
// ----------------------------------------------------------------------------
module go_back_n_link_controller_core #(
    parameter int SEQ_MAX    = gbn_pkg::SEQ_MAX_DEF,
    parameter int DATA_WIDTH = gbn_pkg::DATA_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    gbn_stream_if.sink   req,
    gbn_stream_if.source rsp
);

    gbn_pkg::cmd_t cmd;
    gbn_pkg::sts_t sts;
    gbn_pkg::in_t  req_data;
    gbn_pkg::out_t rsp_data;

    assign req_data = req.data;
    assign rsp.data = rsp_data;

    gbn_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_mode   (req_data.mode),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    gbn_datapath #(
        .SEQ_MAX    (SEQ_MAX),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_data (req_data),
        .cmd      (cmd),
        .sts      (sts),
        .rsp_data (rsp_data)
    );

endmodule

// ===== sim/link_check_pkg.sv =====
// ----------------------------------------------------------------------------
// Go-back-N link controller scoreboard
// Keeps its own copy of the window state, works out the results that each
// accepted request causes and checks every accepted result in order.
// ----------------------------------------------------------------------------
package link_check_pkg;

    import gbn_pkg::*;

    localparam int WINDOW_SIZE = SEQ_MAX_DEF;
    localparam int SEQ_SPAN    = WINDOW_SIZE + 1;

    class link_scoreboard;

        logic [PAYLOAD_W-1:0]   frame_buf [SEQ_SPAN];
        logic [SEQ_FIELD_W-1:0] send_edge;
        logic [SEQ_FIELD_W-1:0] window_base;
        logic [SEQ_FIELD_W-1:0] rx_expected;
        int unsigned            in_flight;
        out_t                   pending_results [$];
        int unsigned            mismatch_count;

        function new();
            foreach (frame_buf[i])
                frame_buf[i] = '0;
            send_edge      = '0;
            window_base    = '0;
            rx_expected    = '0;
            in_flight      = 0;
            mismatch_count = 0;
        endfunction

        function logic [SEQ_FIELD_W-1:0] seq_next(logic [SEQ_FIELD_W-1:0] s);
            return SEQ_FIELD_W'((int'(s) + 1) % SEQ_SPAN);
        endfunction

        // True when b lies in the circular range from a up to, not including, c.
        function bit seq_between(logic [SEQ_FIELD_W-1:0] a, logic [SEQ_FIELD_W-1:0] b,
                                 logic [SEQ_FIELD_W-1:0] c);
            return ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
        endfunction

        function void queue_result(kind_t kind, logic [PAYLOAD_W-1:0] data,
                                   logic [SEQ_FIELD_W-1:0] seq);
            out_t r;
            r.result_kind = kind;
            r.out_data    = data;
            r.out_seq     = seq;
            r.out_ack     = SEQ_FIELD_W'((int'(rx_expected) + WINDOW_SIZE) % SEQ_SPAN);
            r.window_open = (in_flight < WINDOW_SIZE);
            r.last        = 1'b0;
            pending_results.push_back(r);
        endfunction

        function void note_request(in_t t);
            logic [SEQ_FIELD_W-1:0] s;
            bit                     deliver;
            int unsigned            first;
            first = pending_results.size();
            case (t.mode)
                MODE_SEND:
                begin
                    if (in_flight < WINDOW_SIZE) begin
                        s = send_edge;
                        frame_buf[s] = t.payload;
                        in_flight++;
                        send_edge = seq_next(s);
                        queue_result(KIND_FRAME, t.payload, s);
                    end
                    else
                        queue_result(KIND_STATUS, '0, '0);
                end
                MODE_FRAME:
                begin
                    if (^t.payload)
                        queue_result(KIND_STATUS, '0, '0);
                    else begin
                        deliver = (t.rx_seq == rx_expected);
                        if (deliver)
                            rx_expected = seq_next(rx_expected);
                        if (int'(t.rx_ack) < SEQ_SPAN) begin
                            while (in_flight > 0 &&
                                   seq_between(window_base, t.rx_ack, send_edge)) begin
                                in_flight--;
                                window_base = seq_next(window_base);
                            end
                        end
                        if (deliver)
                            queue_result(KIND_DELIVER, t.payload, t.rx_seq);
                        else
                            queue_result(KIND_STATUS, '0, '0);
                    end
                end
                MODE_TIMEOUT:
                begin
                    send_edge = window_base;
                    for (int unsigned i = 0; i < in_flight; i++) begin
                        queue_result(KIND_FRAME, frame_buf[send_edge], send_edge);
                        send_edge = seq_next(send_edge);
                    end
                    if (pending_results.size() == first)
                        queue_result(KIND_STATUS, '0, '0);
                end
                default:
                    queue_result(KIND_STATUS, '0, '0);
            endcase
            pending_results[pending_results.size() - 1].last = 1'b1;
        endfunction

        function void compare_field(string field, logic [PAYLOAD_W-1:0] want,
                                    logic [PAYLOAD_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
                mismatch_count++;
            end
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with none pending, expected none, actual kind %0d data %h",
                         $time, got.result_kind, got.out_data);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("result_kind", want.result_kind, got.result_kind);
            compare_field("out_data", want.out_data, got.out_data);
            compare_field("out_seq", want.out_seq, got.out_seq);
            compare_field("out_ack", want.out_ack, got.out_ack);
            compare_field("window_open", want.window_open, got.window_open);
            compare_field("last", want.last, got.last);
        endfunction

    endclass

endpackage

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// Go-back-N link controller testbench
// Drives directed and random request transactions with random idle gaps and
// response stalls, and checks every response transaction on the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;

    import gbn_pkg::*;
    import link_check_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 20;

    logic           clk = 1'b0;
    logic           rst_n;
    int unsigned    cycle_count = 0;
    int unsigned    req_style;
    int unsigned    rsp_style;
    int unsigned    stall_left;
    link_scoreboard link_sb;

    gbn_stream_if #(.payload_t(in_t))  req_if ();
    gbn_stream_if #(.payload_t(out_t)) rsp_if ();

    go_back_n_link_controller_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always #10 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    always @(posedge clk) begin
        if (rst_n) begin
            if (req_if.valid && req_if.ready)
                link_sb.note_request(req_if.data);
            if (rsp_if.valid && rsp_if.ready)
                link_sb.check_result(rsp_if.data);
        end
    end

    function automatic int unsigned pick_gap(int unsigned style);
        if (style == 0)
            return 0;
        if (style == 1)
            return ($urandom_range(9) < 9) ? $urandom_range(3) : $urandom_range(20, 4);
        return ($urandom_range(9) < 6) ? $urandom_range(4, 1) : $urandom_range(40, 10);
    endfunction

    function automatic in_t make_item(mode_t mode, logic [PAYLOAD_W-1:0] payload,
                                      logic [SEQ_FIELD_W-1:0] rx_seq,
                                      logic [SEQ_FIELD_W-1:0] rx_ack);
        in_t item;
        item.mode    = mode;
        item.payload = payload;
        item.rx_seq  = rx_seq;
        item.rx_ack  = rx_ack;
        return item;
    endfunction

    // Most arriving frames have even parity, the expected sequence number and
    // an ack inside the window, so that deliveries and releases keep going.
    function automatic in_t make_random_item(int unsigned bias);
        in_t         item;
        int unsigned pick;
        int unsigned send_cut;
        int unsigned bit_ix;
        item.payload = $urandom();
        item.rx_seq  = $urandom_range(7);
        item.rx_ack  = $urandom_range(7);
        send_cut = (bias == 1) ? 75 : ((bias == 2) ? 30 : 48);
        pick = $urandom_range(99);
        if (pick < 4)
            item.mode = MODE_UNUSED;
        else if (pick < 14)
            item.mode = MODE_TIMEOUT;
        else if (pick < send_cut)
            item.mode = MODE_SEND;
        else begin
            item.mode = MODE_FRAME;
            if ($urandom_range(9) < 8) begin
                if (^item.payload) begin
                    bit_ix = $urandom_range(PAYLOAD_W - 1);
                    item.payload[bit_ix] = ~item.payload[bit_ix];
                end
                if ($urandom_range(9) < 7)
                    item.rx_seq = link_sb.rx_expected;
                if (link_sb.in_flight != 0 && $urandom_range(9) < 7)
                    item.rx_ack = SEQ_FIELD_W'((int'(link_sb.window_base) +
                                  $urandom_range(link_sb.in_flight - 1)) % SEQ_SPAN);
            end
        end
        return item;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input in_t item, input int unsigned gap);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    initial begin : rsp_ready_gen
        int unsigned cyc;
        cyc        = 0;
        stall_left = 0;
        rsp_style  = 1;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc % 200 == 0)
                rsp_style = $urandom_range(2);
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (rsp_style != 0 && $urandom_range(99) < 25) begin
                stall_left = pick_gap(rsp_style);
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin : stimulus
        int unsigned bias;
        link_sb      = new();
        rst_n        = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;
        req_style    = 1;
        bias         = 0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_request(make_item(MODE_UNUSED, 32'hFFFF_FFFF, 3'd7, 3'd7), pick_gap(1));
        send_request(make_item(MODE_TIMEOUT, 32'h0, 3'd0, 3'd0), pick_gap(1));
        send_request(make_item(MODE_FRAME, 32'h0000_0001, 3'd0, 3'd0), pick_gap(1));
        send_request(make_item(MODE_FRAME, 32'h0, 3'd0, 3'd7), pick_gap(1));
        send_request(make_item(MODE_SEND, 32'h0, 3'd0, 3'd0), 0);
        send_request(make_item(MODE_SEND, 32'hFFFF_FFFF, 3'd7, 3'd7), 0);
        send_request(make_item(MODE_SEND, 32'h8000_0001, 3'd0, 3'd0), pick_gap(1));
        send_request(make_item(MODE_SEND, 32'hA5A5_A5A5, 3'd0, 3'd0), pick_gap(1));
        send_request(make_item(MODE_SEND, 32'h5A5A_5A5A, 3'd0, 3'd0), 0);
        send_request(make_item(MODE_SEND, 32'h1234_5678, 3'd0, 3'd0), pick_gap(1));
        send_request(make_item(MODE_SEND, 32'hFEDC_BA98, 3'd0, 3'd0), pick_gap(1));
        // The window is full now, so this send is refused.
        send_request(make_item(MODE_SEND, 32'hDEAD_BEEF, 3'd0, 3'd0), pick_gap(1));
        send_request(make_item(MODE_TIMEOUT, 32'h0, 3'd0, 3'd0), 0);
        send_request(make_item(MODE_FRAME, 32'h0000_0003, 3'd7, 3'd2), pick_gap(1));
        send_request(make_item(MODE_FRAME, 32'h0000_0007, 3'd1, 3'd6), pick_gap(1));
        send_request(make_item(MODE_FRAME, 32'hFFFF_FFFF, 3'd1, 3'd6), 0);
        send_request(make_item(MODE_TIMEOUT, 32'h0, 3'd0, 3'd0), pick_gap(1));
        send_request(make_item(MODE_SEND, 32'hC000_0003, 3'd0, 3'd0), pick_gap(1));
        send_request(make_item(MODE_FRAME, 32'h0, 3'd2, 3'd0), pick_gap(1));
        send_request(make_item(MODE_FRAME, 32'h0, 3'd3, 3'd7), 0);
        send_request(make_item(MODE_UNUSED, 32'h0, 3'd0, 3'd0), pick_gap(1));

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0)
                req_style = $urandom_range(2);
            if (i % 50 == 0)
                bias = $urandom_range(2);
            send_request(make_random_item(bias), pick_gap(req_style));
        end
        req_if.valid <= 1'b0;

        while (link_sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (link_sb.mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
